// ===== src/csvt_pkg.sv =====
`default_nettype none

package csvt_pkg;

    localparam int unsigned MAX_FIELDS_DEFAULT = 64;
    localparam int unsigned FIELD_NUM_W        = 6;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] CH_QUOTE        = 8'h22;
    localparam logic [7:0] CH_SPACE        = 8'h20;
    localparam logic [7:0] CH_LF           = 8'h0A;
    localparam logic [7:0] CH_CR           = 8'h0D;
    localparam logic [7:0] CH_LOWER_A      = 8'h61;
    localparam logic [7:0] CH_LOWER_Z      = 8'h7A;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ACT_DROP,
        ACT_QUOTE,
        ACT_RECORD,
        ACT_FIELD,
        ACT_CHAR
    } act_t;

    typedef struct packed {
        act_t       act;
        logic [7:0] ch;
    } decode_t;

endpackage

`default_nettype wire

// ===== src/csv_record_tokenizer_unit.sv =====
// CSV tokenizer: takes one text byte per word on in_byte and returns data characters,
// end-of-field and end-of-record markers with their field number. Quotes toggle quoted
// mode and are dropped, the byte after a line end is swallowed, and the first record is
// treated as the header (letters upper-cased, field count kept, later extra fields
// flagged). One byte is taken every cycle while results are being taken; a byte reaches
// the output through an input register and a result register, with the parser state
// updated between them. The separator register (comma after reset) is written through
// the cfg channel, by the user only while the unit is idle; this is not enforced.
`default_nettype none

module csv_record_tokenizer_unit
    import csvt_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [7:0]             cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             in_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  kind,
    output logic [7:0]                  char_value,
    output logic [FIELD_NUM_W-1:0]      field_number,
    output logic                        in_header,
    output logic                        extra_field
);

    logic       sep_reg;
    logic [7:0] separator_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       take;
    kind_t      res_kind;

    assign cfg_ready = 1'b1;
    assign in_ready  = !s1_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEPARATOR_RESET;
            s1_valid_reg  <= 1'b0;
            sep_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                separator_reg <= cfg_data;
                sep_reg       <= 1'b1;
            end
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
    end

    csvt_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s1_valid_reg),
        .byte_value (s1_byte_reg),
        .separator  (separator_reg),
        .take       (take),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res_kind   (res_kind),
        .res_char   (char_value),
        .res_field  (field_number),
        .res_header (in_header),
        .res_extra  (extra_field)
    );

    assign kind = res_kind;

    // input word only leaves its register when the core takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !take |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("input word lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> s1_valid_reg)
        else $error("empty input register taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sep_reg) |-> $past(cfg_valid))
        else $error("separator written without request");

endmodule

`default_nettype wire

// ===== src/csvt_decode.sv =====
`default_nettype none

module csvt_decode
    import csvt_pkg::*;
(
    input  wire logic [7:0] byte_value,
    input  wire logic [7:0] separator,
    input  wire logic       quoted,
    input  wire logic       swallow,
    input  wire logic       header,
    output decode_t         dec
);

    logic is_line_end;
    logic is_lower;

    assign is_line_end = (byte_value == CH_CR) || (byte_value == CH_LF);
    assign is_lower    = (byte_value >= CH_LOWER_A) && (byte_value <= CH_LOWER_Z);

    always_comb
    begin
        dec.ch = 8'd0;
        priority if (swallow)
        begin
            dec.act = ACT_DROP;
        end
        else if (byte_value == CH_QUOTE)
        begin
            dec.act = ACT_QUOTE;
        end
        else if (!quoted && is_line_end)
        begin
            dec.act = ACT_RECORD;
        end
        else if (!quoted && (byte_value == separator))
        begin
            dec.act = ACT_FIELD;
        end
        else if (!quoted && (byte_value < CH_SPACE))
        begin
            dec.act = ACT_DROP;
        end
        else
        begin
            dec.act = ACT_CHAR;
            // header text is upper-cased
            dec.ch  = (header && is_lower) ? (byte_value - CASE_OFFSET) : byte_value;
        end
    end

endmodule

`default_nettype wire

// ===== src/csvt_core.sv =====
`default_nettype none

module csvt_core
    import csvt_pkg::*;
#(
    parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_valid,
    input  wire logic [7:0]             byte_value,
    input  wire logic [7:0]             separator,
    output logic                        take,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output kind_t                       res_kind,
    output logic [7:0]                  res_char,
    output logic [FIELD_NUM_W-1:0]      res_field,
    output logic                        res_header,
    output logic                        res_extra
);

    localparam int unsigned FC_W = $clog2(MAX_FIELDS);
    localparam int unsigned HW_W = FC_W + 1;
    localparam logic [FC_W-1:0] FC_LAST = FC_W'(MAX_FIELDS - 1);

    logic            quoted_reg;
    logic            swallow_reg;
    logic [FC_W-1:0] fc_reg;
    logic            header_reg;
    logic [HW_W-1:0] hw_reg;

    logic                   res_valid_reg;
    kind_t                  kind_reg;
    logic [7:0]             char_reg;
    logic [FIELD_NUM_W-1:0] field_reg;
    logic                   header_out_reg;
    logic                   extra_reg;

    decode_t dec;
    logic    emit;
    kind_t   kind_next;
    logic    extra_next;

    csvt_decode u_decode
    (
        .byte_value (byte_value),
        .separator  (separator),
        .quoted     (quoted_reg),
        .swallow    (swallow_reg),
        .header     (header_reg),
        .dec        (dec)
    );

    assign emit = (dec.act == ACT_RECORD) || (dec.act == ACT_FIELD) || (dec.act == ACT_CHAR);
    assign take = byte_valid && (!res_valid_reg || res_ready || !emit);

    assign extra_next = !header_reg && ({1'b0, fc_reg} >= hw_reg);

    always_comb
    begin
        unique case (dec.act)
            ACT_RECORD: kind_next = KIND_RECORD_END;
            ACT_FIELD:  kind_next = KIND_FIELD_END;
            default:    kind_next = KIND_CHAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg    <= 1'b0;
            swallow_reg   <= 1'b0;
            fc_reg        <= '0;
            header_reg    <= 1'b1;
            hw_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                unique case (dec.act)
                    ACT_DROP:
                    begin
                        swallow_reg <= 1'b0;
                    end
                    ACT_QUOTE:
                    begin
                        quoted_reg <= !quoted_reg;
                    end
                    ACT_RECORD:
                    begin
                        if (header_reg)
                        begin
                            hw_reg     <= HW_W'(fc_reg) + HW_W'(1);
                            header_reg <= 1'b0;
                        end
                        fc_reg      <= '0;
                        swallow_reg <= 1'b1;
                    end
                    ACT_FIELD:
                    begin
                        if (fc_reg < FC_LAST)
                        begin
                            fc_reg <= fc_reg + FC_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (take && emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            kind_reg       <= kind_next;
            char_reg       <= dec.ch;
            field_reg      <= FIELD_NUM_W'(fc_reg);
            header_out_reg <= header_reg;
            extra_reg      <= extra_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_kind   = kind_reg;
    assign res_char   = char_reg;
    assign res_field  = field_reg;
    assign res_header = header_out_reg;
    assign res_extra  = extra_reg;

    // a held result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |-> !(take && emit))
        else $error("held result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        take && (dec.act == ACT_RECORD) |=> swallow_reg && (fc_reg == '0))
        else $error("record end did not arm swallow");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(header_reg) |-> $past(take && (dec.act == ACT_RECORD)))
        else $error("header left without record end");

    assert property (@(posedge clk) disable iff (!rst_n)
        !header_reg |-> (hw_reg != '0))
        else $error("header width not latched");

endmodule

`default_nettype wire
